### hdl/utf8_sanitizer_defines.svh
// utf8_sanitizer_defines.svh: assertion macros for the utf8 sanitizer checker
// depends on nothing; included by files that hold concurrent assertions
`ifndef UTF8_SANITIZER_DEFINES_SVH
`define UTF8_SANITIZER_DEFINES_SVH

// clocked assertion, disabled while reset is asserted (active low)
`define U8S_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion that a request held by a stalled receiver keeps its payload
`define U8S_ASSERT_HOLD(lbl, clk, rst_n, vld, rdy, pay, msg) \
  `U8S_ASSERT(lbl, clk, rst_n, (vld && !rdy) |=> (vld && $stable(pay)), msg)

`endif

### hdl/utf8s_pkg.sv
// utf8s_pkg: types, constants and byte classification for the utf8 sanitizer
// depends on nothing; imported by the controller, datapath and top level
package utf8s_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_EMIT
  } state_e;

  // verdict on the byte at the head of the window
  typedef enum logic [1:0] {
    ACT_DONE,
    ACT_PASS,
    ACT_REPL,
    ACT_HOLD
  } act_e;

  typedef struct packed {
    logic load;
    logic start;
    logic emit;
    logic compact;
  } cmd_t;

  typedef struct packed {
    act_e act;
    logic emit_final;
    logic out_free;
  } status_t;

  localparam logic [7:0] LEAD2_MIN  = 8'hC2;
  localparam logic [7:0] LEAD2_MAX  = 8'hDF;
  localparam logic [7:0] LEAD3_MIN  = 8'hE0;
  localparam logic [7:0] LEAD3_MAX  = 8'hEF;
  localparam logic [7:0] LEAD4_MIN  = 8'hF0;
  localparam logic [7:0] LEAD4_MAX  = 8'hF4;
  localparam logic [7:0] LEAD_SURR  = 8'hED;
  localparam logic [7:0] CONT_A0    = 8'hA0;
  localparam logic [7:0] CONT_8F    = 8'h8F;
  localparam logic [7:0] CONT_90    = 8'h90;
  localparam logic [7:0] REPL_B0    = 8'hEF;
  localparam logic [7:0] REPL_B1    = 8'hBF;
  localparam logic [7:0] REPL_B2    = 8'hBD;
  localparam logic [2:0] REPL_LEN   = 3'd3;

  // length announced by a lead byte, 0 when it never starts a sequence
  function automatic logic [2:0] seq_len(input logic [7:0] c);
    logic [2:0] len;
    if (c[7] == 1'b0) len = 3'd1;
    else if (c >= LEAD2_MIN && c <= LEAD2_MAX) len = 3'd2;
    else if (c >= LEAD3_MIN && c <= LEAD3_MAX) len = 3'd3;
    else if (c >= LEAD4_MIN && c <= LEAD4_MAX) len = 3'd4;
    else len = 3'd0;
    return len;
  endfunction

  function automatic logic is_cont(input logic [7:0] b);
    return b[7:6] == 2'b10;
  endfunction

  // second byte check with overlong, surrogate and range limits
  function automatic logic second_ok(input logic [7:0] lead, input logic [7:0] b);
    logic ok;
    if (!is_cont(b)) ok = 1'b0;
    else if (lead == LEAD3_MIN) ok = (b >= CONT_A0);
    else if (lead == LEAD_SURR) ok = (b < CONT_A0);
    else if (lead == LEAD4_MIN) ok = (b >= CONT_90);
    else if (lead == LEAD4_MAX) ok = (b <= CONT_8F);
    else ok = 1'b1;
    return ok;
  endfunction

endpackage

### hdl/utf8s_datapath.sv
// utf8s_datapath: byte window, head classification and output register
// depends on utf8s_pkg; driven by utf8s_ctrl through cmd_t and status_t
module utf8s_datapath import utf8s_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       cmd_i,
  output status_t    status_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  logic [7:0] win_q [4];
  logic [2:0] cnt_q, pos_q;
  logic [1:0] idx_q;
  logic       last_q;
  act_e       kind_q;
  logic [2:0] len_q;
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_last_q;

  logic [7:0] head, b1, b2, b3, emit_byte;
  logic [2:0] avail, hlen, p1, p2, p3, pe, pos_fin;
  logic       bad, emit_final;
  act_e       verdict;

  // head classification
  always_comb begin
    p1    = pos_q + 3'd1;
    p2    = pos_q + 3'd2;
    p3    = pos_q + 3'd3;
    head  = win_q[pos_q[1:0]];
    b1    = win_q[p1[1:0]];
    b2    = win_q[p2[1:0]];
    b3    = win_q[p3[1:0]];
    avail = cnt_q - pos_q;
    hlen  = seq_len(head);
    bad   = (hlen == 3'd0)
          || (hlen >= 3'd2 && avail >= 3'd2 && !second_ok(head, b1))
          || (hlen >= 3'd3 && avail >= 3'd3 && !is_cont(b2))
          || (hlen == 3'd4 && avail >= 3'd4 && !is_cont(b3));
    if (pos_q == cnt_q) verdict = ACT_DONE;
    else if (hlen == 3'd1) verdict = ACT_PASS;
    else if (!bad && avail >= hlen) verdict = ACT_PASS;
    else if (bad || last_q) verdict = ACT_REPL;
    else verdict = ACT_HOLD;
  end

  // byte of the running action
  always_comb begin
    pe = pos_q + {1'b0, idx_q};
    if (kind_q == ACT_PASS) begin
      emit_byte = win_q[pe[1:0]];
    end else begin
      case (idx_q)
        2'd0:    emit_byte = REPL_B0;
        2'd1:    emit_byte = REPL_B1;
        default: emit_byte = REPL_B2;
      endcase
    end
    emit_final = ({1'b0, idx_q} == (len_q - 3'd1));
    pos_fin    = (kind_q == ACT_PASS) ? (pos_q + len_q) : p1;
  end

  assign status_o.act        = verdict;
  assign status_o.emit_final = emit_final;
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= 3'd0;
      pos_q       <= 3'd0;
      idx_q       <= 2'd0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        cnt_q  <= cnt_q + 3'd1;
        last_q <= in_last_i;
      end
      if (cmd_i.start) begin
        idx_q <= 2'd0;
      end
      if (cmd_i.emit) begin
        if (emit_final) begin
          pos_q <= pos_fin;
          idx_q <= 2'd0;
        end else begin
          idx_q <= idx_q + 2'd1;
        end
      end
      if (cmd_i.compact) begin
        cnt_q <= avail;
        pos_q <= 3'd0;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    logic [2:0] src;
    if (cmd_i.load) begin
      win_q[cnt_q[1:0]] <= in_byte_i;
    end
    if (cmd_i.compact) begin
      for (int i = 0; i < 4; i++) begin
        src = pos_q + 3'(i);
        win_q[i] <= (src < cnt_q) ? win_q[src[1:0]] : 8'h00;
      end
    end
    if (cmd_i.start) begin
      kind_q <= verdict;
      len_q  <= (verdict == ACT_PASS) ? hlen : REPL_LEN;
    end
    if (cmd_i.emit) begin
      out_byte_q <= emit_byte;
      out_last_q <= last_q && emit_final && (pos_fin == cnt_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

endmodule

### hdl/utf8s_ctrl.sv
// utf8s_ctrl: state machine that sequences load, evaluate and emit steps
// depends on utf8s_pkg; commands utf8s_datapath
module utf8s_ctrl import utf8s_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (status_i.act == ACT_DONE || status_i.act == ACT_HOLD) state_d = ST_IDLE;
        else state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free && status_i.emit_final) state_d = ST_EVAL;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_EVAL: begin
        if (status_i.act == ACT_DONE || status_i.act == ACT_HOLD) cmd_o.compact = 1'b1;
        else cmd_o.start = 1'b1;
      end
      ST_EMIT: begin
        cmd_o.emit = status_i.out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### hdl/utf8_sanitizer.sv
// utf8_sanitizer: top level of the utf8 sanitizer, controller plus datapath
// depends on utf8s_pkg, utf8s_ctrl and utf8s_datapath
//
// usage
//   input channel: in_valid_i / in_ready_o carry one raw byte per request,
//     in_last_i marks the end of a string and flushes every held byte
//   output channel: out_valid_o / out_ready_i carry one sanitized byte per
//     request, out_last_o rides on the final byte caused by a string end
//   a request is taken one byte at a time: accept in idle, evaluate the
//     window head for each sequence to resolve and for the final check, then
//     emit the bytes of each action before evaluating again
//   throughput is set by the single emit path: at most one output byte per
//     cycle while the output is free, and an evaluate step between actions
//   out_valid_o first rises after accept once evaluate and emit have run
//   a bad lead becomes ef bf bd and the bytes behind it are looked at again
//   up to three bytes of an unfinished sequence stay held between requests
//   reset empties the window and drops the output register; no clearing pass
//   a stalled receiver freezes the emit step; input is only taken once every
//     byte resolved from the previous request is in the output register
module utf8_sanitizer import utf8s_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  // command and status between the two halves
  cmd_t    cmd;
  status_t status;

  // sequencer: idle, evaluate head, emit bytes of one action
  utf8s_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // window of held bytes, head checks and output register
  utf8s_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_byte_i   (in_byte_i),
    .in_last_i   (in_last_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o)
  );

endmodule

### hdl/utf8s_checker.sv
// utf8s_checker: port-level assertions for the utf8 sanitizer
// depends on utf8_sanitizer_defines.svh; bound to utf8_sanitizer below
`include "utf8_sanitizer_defines.svh"

module utf8s_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic       out_last_o
);

  // a stalled output request keeps its byte and end mark
  `U8S_ASSERT_HOLD(a_out_hold, clk_i, rst_ni, out_valid_o, out_ready_i, {out_byte_o, out_last_o}, "output request changed while stalled")

  // an accepted input request drops ready in the cycle after it is taken
  `U8S_ASSERT(a_busy_after_accept, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> !in_ready_o, "ready stayed high after accept")

  // a new output byte only appears while a request is being worked on
  `U8S_ASSERT(a_out_while_busy, clk_i, rst_ni, $rose(out_valid_o) |-> !in_ready_o, "output appeared while idle")

  // ready only drops because an input request was taken
  `U8S_ASSERT(a_ready_fall, clk_i, rst_ni, $fell(in_ready_o) |-> $past(in_valid_i), "ready fell without a request")

endmodule

bind utf8_sanitizer utf8s_checker u_utf8s_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_byte_o  (out_byte_o),
  .out_last_o  (out_last_o)
);

### verif/tb_utf8_sanitizer.sv
// tb_utf8_sanitizer: self-checking testbench for the utf8 sanitizer
// holds a scoreboard class with its own byte-window predictor and the top module
// depends on utf8s_pkg for the lead and continuation limits, and on the utf8_sanitizer rtl
`timescale 1ns / 1ps

import utf8s_pkg::*;

class utf8_scoreboard;
  typedef struct {
    logic [7:0] b;
    logic       l;
  } out_rec_t;

  out_rec_t    want_q[$];
  logic [7:0]  held[3];
  int unsigned held_n;
  int unsigned errors;
  int unsigned checked;

  function new();
    held    = '{default: 8'h00};
    held_n  = 0;
    errors  = 0;
    checked = 0;
  endfunction

  function int unsigned lead_len(logic [7:0] c);
    if (c[7] == 1'b0) return 1;
    if (c >= LEAD2_MIN && c <= LEAD2_MAX) return 2;
    if (c >= LEAD3_MIN && c <= LEAD3_MAX) return 3;
    if (c >= LEAD4_MIN && c <= LEAD4_MAX) return 4;
    return 0;
  endfunction

  function bit second_fits(logic [7:0] lead, logic [7:0] b);
    if (b[7:6] != 2'b10) return 1'b0;
    if (lead == LEAD3_MIN) return b >= CONT_A0;
    if (lead == LEAD_SURR) return b < CONT_A0;
    if (lead == LEAD4_MIN) return b >= CONT_90;
    if (lead == LEAD4_MAX) return b <= CONT_8F;
    return 1'b1;
  endfunction

  function void push_out(logic [7:0] b);
    out_rec_t r;
    r.b = b;
    r.l = 1'b0;
    want_q.insert(want_q.size(), r);
  endfunction

  // accepted request: resolve the held window plus the new byte
  function void note_request(logic [7:0] b, logic l);
    logic [7:0]  win[4];
    int unsigned n;
    int unsigned pos;
    int unsigned k;
    int unsigned len;
    int unsigned avail;
    int unsigned start;
    bit          bad;
    start = want_q.size();
    for (k = 0; k < held_n; k++) win[k] = held[k];
    win[held_n] = b;
    n   = held_n + 1;
    pos = 0;
    while (pos < n) begin
      len   = lead_len(win[pos]);
      avail = n - pos;
      bad   = (len == 0);
      if (len == 1) begin
        push_out(win[pos]);
        pos++;
      end else begin
        for (k = 1; !bad && k < len && k < avail; k++) begin
          bad = (k == 1) ? !second_fits(win[pos], win[pos + k]) : (win[pos + k][7:6] != 2'b10);
        end
        if (!bad && avail >= len) begin
          for (k = 0; k < len; k++) push_out(win[pos + k]);
          pos += len;
        end else if (bad || l) begin
          push_out(REPL_B0);
          push_out(REPL_B1);
          push_out(REPL_B2);
          pos++;
        end else begin
          break;
        end
      end
    end
    held_n = n - pos;
    for (k = 0; k < held_n; k++) held[k] = win[pos + k];
    if (l && want_q.size() > start) want_q[want_q.size() - 1].l = 1'b1;
  endfunction

  function int unsigned outstanding();
    return want_q.size();
  endfunction

  task report(string what, logic [7:0] got, logic [7:0] want);
    $display("[%0t] mismatch on %s: got %02h, want %02h", $time, what, got, want);
    errors++;
  endtask

  task check_result(logic [7:0] b, logic l);
    out_rec_t r;
    checked++;
    if (want_q.size() == 0) begin
      report("unexpected byte", b, 8'h00);
    end else begin
      r = want_q.pop_front();
      if (b !== r.b) report("out_byte", b, r.b);
      if (l !== r.l) report("out_last", {7'd0, l}, {7'd0, r.l});
    end
  endtask
endclass

module tb_utf8_sanitizer;

  typedef struct packed {
    logic [7:0] b;
    logic       l;
  } req_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic [7:0] in_byte_i   = 8'h00;
  logic       in_last_i   = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       out_last_o;

  utf8_scoreboard sb = new();

  req_t        stim_q[$];
  int unsigned send_idle_pct = 31;
  int unsigned recv_idle_pct = 69;
  int unsigned n_sent    = 0;
  int unsigned n_strings = 0;

  utf8_sanitizer DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_byte_o (out_byte_o),
    .out_last_o (out_last_o)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // receiver back-pressure, changed on the falling edge only
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // every accepted output byte goes to the scoreboard
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_byte_o, out_last_o);
  end

  // stimulus building

  function automatic void push_req(logic [7:0] b, logic l);
    req_t r;
    r.b = b;
    r.l = l;
    stim_q.insert(stim_q.size(), r);
  endfunction

  function automatic logic [7:0] any_cont();
    return {2'b10, 6'($urandom_range(63))};
  endfunction

  // byte that breaks a continuation slot
  function automatic logic [7:0] non_cont();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if (b[7:6] == 2'b10) b[6] = 1'b1;
    return b;
  endfunction

  // second byte inside the legal window of this lead
  function automatic logic [7:0] good_second(logic [7:0] lead);
    case (lead)
      LEAD3_MIN: return 8'($urandom_range(CONT_A0, 8'hBF));
      LEAD_SURR: return 8'($urandom_range(8'h80, 8'h9F));
      LEAD4_MIN: return 8'($urandom_range(CONT_90, 8'hBF));
      LEAD4_MAX: return 8'($urandom_range(8'h80, CONT_8F));
      default:   return any_cont();
    endcase
  endfunction

  // second byte just outside the window: overlong, surrogate, above range, or no continuation
  function automatic logic [7:0] bad_second(logic [7:0] lead);
    case (lead)
      LEAD3_MIN: return 8'($urandom_range(8'h80, 8'h9F));
      LEAD_SURR: return 8'($urandom_range(CONT_A0, 8'hBF));
      LEAD4_MIN: return 8'($urandom_range(8'h80, CONT_8F));
      LEAD4_MAX: return 8'($urandom_range(CONT_90, 8'hBF));
      default:   return non_cont();
    endcase
  endfunction

  // lead of a given length, leaning on the leads with a narrow second byte
  function automatic logic [7:0] pick_lead(int unsigned len);
    bit edge_lead;
    edge_lead = ($urandom_range(3) == 0);
    case (len)
      2:       return 8'($urandom_range(LEAD2_MIN, LEAD2_MAX));
      3:       return edge_lead ? ($urandom_range(1) ? LEAD3_MIN : LEAD_SURR)
                                : 8'($urandom_range(LEAD3_MIN, LEAD3_MAX));
      default: return edge_lead ? ($urandom_range(1) ? LEAD4_MIN : LEAD4_MAX)
                                : 8'($urandom_range(LEAD4_MIN, LEAD4_MAX));
    endcase
  endfunction

  // one character: mostly well-formed, some cut short or broken, some raw noise
  function automatic void add_char();
    logic [7:0]  seq[4];
    int unsigned kind;
    int unsigned len;
    int unsigned cut;
    int unsigned k;
    kind = $urandom_range(99);
    if (kind < 30) begin
      push_req(8'($urandom_range(127)), 1'b0);
    end else if (kind < 85) begin
      len    = $urandom_range(2, 4);
      seq[0] = pick_lead(len);
      seq[1] = good_second(seq[0]);
      seq[2] = any_cont();
      seq[3] = any_cont();
      if (kind < 70) begin
        cut = len;
      end else if (kind < 78) begin
        // truncated sequence
        cut = $urandom_range(1, len - 1);
      end else begin
        // broken continuation at some slot
        cut = $urandom_range(1, len - 1);
        seq[cut] = (cut == 1) ? bad_second(seq[0]) : non_cont();
        cut++;
      end
      for (k = 0; k < cut; k++) push_req(seq[k], 1'b0);
    end else begin
      push_req(8'($urandom_range(255)), 1'b0);
    end
  endfunction

  // a string of a few characters, usually closed by the end mark
  function automatic void add_string();
    int unsigned nchar;
    nchar = $urandom_range(1, 6);
    repeat (nchar) add_char();
    if ($urandom_range(99) < 85) stim_q[stim_q.size() - 1].l = 1'b1;
  endfunction

  function automatic void fill_random(int unsigned n);
    while (stim_q.size() < n) add_string();
  endfunction

  // directed opening: ascii limits, each lead class, each kind of bad sequence
  function automatic void add_directed();
    push_req(8'h00, 1'b0);
    push_req(8'h7F, 1'b1);              // end mark on a plain byte
    push_req(8'hC2, 1'b0);
    push_req(8'h80, 1'b0);              // smallest two byte form
    push_req(8'hE0, 1'b0);
    push_req(8'h9F, 1'b0);              // overlong three byte form
    push_req(8'hED, 1'b0);
    push_req(8'hA0, 1'b0);              // surrogate
    push_req(8'hF0, 1'b0);
    push_req(8'h90, 1'b0);
    push_req(8'h80, 1'b0);
    push_req(8'h80, 1'b0);              // smallest four byte form
    push_req(8'hF4, 1'b0);
    push_req(8'h90, 1'b0);              // above U+10FFFF
    push_req(8'hC0, 1'b0);              // leads that never start a sequence
    push_req(8'hF5, 1'b0);
    push_req(8'hFF, 1'b0);
    push_req(8'h80, 1'b0);              // stray continuation
    push_req(8'hC3, 1'b0);
    push_req(8'h41, 1'b0);              // bad continuation
    push_req(8'hF0, 1'b0);
    push_req(8'h8F, 1'b0);              // overlong four byte form
    push_req(8'hE1, 1'b0);
    push_req(8'h80, 1'b1);              // cut off by the end of the string
  endfunction

  // driving

  // one request: optional idle gap, then hold valid until accepted
  task automatic send_byte(logic [7:0] b, logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    in_last_i  <= l;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(b, l);
    @(negedge clk_i);
  endtask

  task automatic drive_all();
    req_t r;
    while (stim_q.size() != 0) begin
      r = stim_q.pop_front();
      send_byte(r.b, r.l);
      n_sent++;
      if (r.l) n_strings++;
    end
  endtask

  // sender holds off until every expected byte has come out
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (sb.outstanding() != 0);
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // phase 1: slow receiver, directed then random
    send_idle_pct = 31;
    recv_idle_pct = 69;
    add_directed();
    drive_all();
    fill_random(80);
    drive_all();
    drain();

    // phase 2: slow sender
    send_idle_pct = 69;
    recv_idle_pct = 31;
    fill_random(80);
    drive_all();
    drain();

    // phase 3: full rate on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fill_random(80);
    drive_all();
    drain();

    // let any stray output show up
    repeat (32) @(posedge clk_i);

    $display("covered %0d input bytes over %0d marked strings, %0d output bytes checked",
             n_sent, n_strings, sb.checked);
    $display("idle mixes run: slow receiver, slow sender, then no idling");
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("timeout: run did not finish, %0d bytes still expected", sb.outstanding());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
